FILE: rtl/core/rrd_pkg.sv
// Shared types and character codes for the request deframer.
// Used by the number line checker, the parser, the output register and the top level.
// No dependencies.
`default_nettype none

package rrd_pkg;

  localparam int unsigned FIELD_W = 32;

  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_START = 3'd1,
    KIND_BYTE  = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_ERROR = 3'd4
  } kind_e;

  // Status of the decimal number line being read.
  typedef struct packed {
    logic negative;
    logic has_digit;
    logic bad;
    logic cr_pending;
  } line_flags_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         data_byte;
    logic [FIELD_W-1:0] arg_index;
    logic [FIELD_W-1:0] arg_length;
    logic               arg_last_byte;
    logic [FIELD_W-1:0] arg_count;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/resp_request_deframer_unit.sv
// Top level of the request deframer: parser plus result register.
// Depends on rrd_pkg, rrd_parser (with rrd_num_line) and rrd_out_reg.
//
// Usage:
//   Input channel: one request byte per word on byte_req_i, qualified by
//   in_valid_i and accepted when in_stall_o is low.
//   Output channel: exactly one result word per accepted byte (kind may be
//   none), qualified by out_valid_o and taken when out_stall_i is low.
//   The result of an accepted byte is registered and shown on the outputs in the cycle after acceptance.
//   Throughput is one byte per cycle while in_stall_o is low; the parser keeps
//   only running counters and a single result register decouples the channels.
//   in_stall_o rises only while the result register is full and the receiver
//   stalls; the pending result and all parser state then hold.
//   Reset empties the result register and returns the parser to waiting for
//   an array marker. A protocol error is reported once and the block then
//   yields kind none for every byte until the next reset.
//   NUMBER_WIDTH sets the widest accepted count or length; larger values
//   are protocol errors.
`default_nettype none

module resp_request_deframer_unit #(
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_req_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [7:0]       data_byte_o,
  output logic [31:0]      arg_index_o,
  output logic [31:0]      arg_length_o,
  output logic             arg_last_byte_o,
  output logic [31:0]      arg_count_o
);
  import rrd_pkg::*;

  logic    accept;
  logic    busy;
  result_t parsed;
  result_t held;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  rrd_parser #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (accept),
    .byte_i  (byte_req_i),
    .result_o(parsed)
  );

  rrd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .result_i   (parsed),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .busy_o     (busy),
    .result_o   (held)
  );

  assign kind_o          = held.kind;
  assign data_byte_o     = held.data_byte;
  assign arg_index_o     = held.arg_index;
  assign arg_length_o    = held.arg_length;
  assign arg_last_byte_o = held.arg_last_byte;
  assign arg_count_o     = held.arg_count;

endmodule

`default_nettype wire

FILE: rtl/core/rrd_num_line.sv
// Next-state logic for one byte of a decimal number line ending in CR LF.
// Depends on rrd_pkg for character codes and the line flag struct.
`default_nettype none

module rrd_num_line #(
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  wire logic [7:0]              byte_i,
  input  wire logic [NUMBER_WIDTH-1:0] accum_i,
  input  wire rrd_pkg::line_flags_t    flags_i,
  output logic [NUMBER_WIDTH-1:0]      accum_o,
  output rrd_pkg::line_flags_t         flags_o,
  output logic                         line_end_o,
  output logic                         line_valid_o
);
  import rrd_pkg::*;

  localparam int unsigned PROD_W = NUMBER_WIDTH + 4;

  logic              is_digit;
  logic [3:0]        digit;
  logic [PROD_W-1:0] accum_ext;
  logic [PROD_W-1:0] scaled;
  logic              too_wide;

  assign is_digit  = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign digit     = 4'(byte_i - CHAR_ZERO);
  assign accum_ext = PROD_W'(accum_i);
  // accum * 10 + digit; anything above the number width overflows
  assign scaled    = (accum_ext << 3) + (accum_ext << 1) + PROD_W'(digit);
  assign too_wide  = |scaled[PROD_W-1:NUMBER_WIDTH];

  assign line_valid_o = !flags_i.bad && flags_i.has_digit &&
                        !(flags_i.negative && (accum_i != '0));

  always_comb begin
    accum_o    = accum_i;
    flags_o    = flags_i;
    line_end_o = 1'b0;
    if (flags_i.cr_pending && (byte_i == CHAR_LF)) begin
      flags_o.cr_pending = 1'b0;
      line_end_o         = 1'b1;
    end else begin
      // A CR not followed by LF spoils the line
      if (flags_i.cr_pending) begin
        flags_o.cr_pending = 1'b0;
        flags_o.bad        = 1'b1;
      end
      priority if (byte_i == CHAR_CR) begin
        flags_o.cr_pending = 1'b1;
      end else if (is_digit) begin
        flags_o.has_digit = 1'b1;
        if (too_wide) begin
          flags_o.bad = 1'b1;
        end else begin
          accum_o = scaled[NUMBER_WIDTH-1:0];
        end
      end else if (byte_i == CHAR_MINUS && !flags_i.negative && !flags_i.has_digit) begin
        flags_o.negative = 1'b1;
      end else begin
        flags_o.bad = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rrd_parser.sv
// Framing state machine: phase, counters and the number line registers.
// Depends on rrd_pkg and rrd_num_line; produces one result per accepted word.
`default_nettype none

module rrd_parser #(
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output rrd_pkg::result_t result_o
);
  import rrd_pkg::*;

  typedef enum logic [2:0] {
    PH_ARRAY_MARK = 3'd0,
    PH_ARRAY_NUM  = 3'd1,
    PH_BULK_MARK  = 3'd2,
    PH_BULK_NUM   = 3'd3,
    PH_PAYLOAD    = 3'd4,
    PH_TRAIL1     = 3'd5,
    PH_TRAIL2     = 3'd6,
    PH_ERROR      = 3'd7
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [NUMBER_WIDTH-1:0] accum_q, accum_d;
  line_flags_t             flags_q, flags_d;
  logic [NUMBER_WIDTH-1:0] args_left_q, args_left_d;
  logic [FIELD_W-1:0]      arg_pos_q, arg_pos_d;
  logic [NUMBER_WIDTH-1:0] data_left_q, data_left_d;
  logic [NUMBER_WIDTH-1:0] cmd_args_q, cmd_args_d;

  logic [NUMBER_WIDTH-1:0] nl_accum;
  line_flags_t             nl_flags;
  logic                    nl_end;
  logic                    nl_valid;
  logic [NUMBER_WIDTH-1:0] data_left_dec;
  logic [NUMBER_WIDTH-1:0] args_left_dec;

  rrd_num_line #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_num_line (
    .byte_i      (byte_i),
    .accum_i     (accum_q),
    .flags_i     (flags_q),
    .accum_o     (nl_accum),
    .flags_o     (nl_flags),
    .line_end_o  (nl_end),
    .line_valid_o(nl_valid)
  );

  assign data_left_dec = (data_left_q != '0) ? data_left_q - NUMBER_WIDTH'(1) : data_left_q;
  assign args_left_dec = (args_left_q != '0) ? args_left_q - NUMBER_WIDTH'(1) : args_left_q;

  always_comb begin
    phase_d     = phase_q;
    accum_d     = accum_q;
    flags_d     = flags_q;
    args_left_d = args_left_q;
    arg_pos_d   = arg_pos_q;
    data_left_d = data_left_q;
    cmd_args_d  = cmd_args_q;
    result_o    = '0;
    result_o.kind = KIND_NONE;

    unique case (phase_q)
      PH_ARRAY_MARK: begin
        if (byte_i == CHAR_STAR) begin
          accum_d = '0;
          flags_d = '0;
          phase_d = PH_ARRAY_NUM;
        end else begin
          result_o.kind = KIND_ERROR;
          phase_d       = PH_ERROR;
        end
      end
      PH_ARRAY_NUM: begin
        accum_d = nl_accum;
        flags_d = nl_flags;
        if (nl_end) begin
          if (!nl_valid) begin
            result_o.kind = KIND_ERROR;
            phase_d       = PH_ERROR;
          end else if (accum_q == '0) begin
            result_o.kind = KIND_DONE;
            phase_d       = PH_ARRAY_MARK;
          end else begin
            args_left_d = accum_q;
            cmd_args_d  = accum_q;
            arg_pos_d   = '0;
            phase_d     = PH_BULK_MARK;
          end
        end
      end
      PH_BULK_MARK: begin
        // A missing '$' is only reported once the line ends
        accum_d            = '0;
        flags_d            = '0;
        flags_d.bad        = (byte_i != CHAR_DOLLAR);
        flags_d.cr_pending = (byte_i == CHAR_CR);
        phase_d            = PH_BULK_NUM;
      end
      PH_BULK_NUM: begin
        accum_d = nl_accum;
        flags_d = nl_flags;
        if (nl_end) begin
          if (!nl_valid) begin
            result_o.kind = KIND_ERROR;
            phase_d       = PH_ERROR;
          end else begin
            data_left_d         = accum_q;
            result_o.kind       = KIND_START;
            result_o.arg_index  = arg_pos_q;
            result_o.arg_length = FIELD_W'(accum_q);
            phase_d             = (accum_q == '0) ? PH_TRAIL1 : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        result_o.kind          = KIND_BYTE;
        result_o.data_byte     = byte_i;
        result_o.arg_index     = arg_pos_q;
        result_o.arg_last_byte = (data_left_q <= NUMBER_WIDTH'(1));
        data_left_d            = data_left_dec;
        if (data_left_dec == '0) begin
          phase_d = PH_TRAIL1;
        end
      end
      PH_TRAIL1: begin
        phase_d = PH_TRAIL2;
      end
      PH_TRAIL2: begin
        args_left_d = args_left_dec;
        arg_pos_d   = arg_pos_q + FIELD_W'(1);
        if (args_left_dec == '0) begin
          result_o.kind      = KIND_DONE;
          result_o.arg_count = FIELD_W'(cmd_args_q);
          phase_d            = PH_ARRAY_MARK;
        end else begin
          phase_d = PH_BULK_MARK;
        end
      end
      PH_ERROR: begin
        phase_d = PH_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_ARRAY_MARK;
      accum_q     <= '0;
      flags_q     <= '0;
      args_left_q <= '0;
      arg_pos_q   <= '0;
      data_left_q <= '0;
      cmd_args_q  <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      accum_q     <= accum_d;
      flags_q     <= flags_d;
      args_left_q <= args_left_d;
      arg_pos_q   <= arg_pos_d;
      data_left_q <= data_left_d;
      cmd_args_q  <= cmd_args_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rrd_out_reg.sv
// Result register between the parser and the output channel.
// Depends on rrd_pkg for the result struct.
`default_nettype none

module rrd_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire rrd_pkg::result_t result_i,
  input  wire logic             out_stall_i,
  output logic                  out_valid_o,
  output logic                  busy_o,
  output rrd_pkg::result_t      result_o
);
  import rrd_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // Full and not drained this cycle: hold the upstream side
  assign busy_o      = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;
  assign valid_d     = load_i || busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

`default_nettype wire
